// File: rtl/core/servo_bus_status_packet_receiver_macros.svh
// Assertion macros used by the servo-bus status packet receiver parser.
`ifndef SERVO_BUS_STATUS_PACKET_RECEIVER_MACROS_SVH
`define SERVO_BUS_STATUS_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sbsr_pkg.sv
// Types and constants of the servo-bus status packet receiver.
package sbsr_pkg;

	localparam int TIME_W = 25;
	localparam int POS_W = 9;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int DEFAULT_BUFFER_BYTES = 128;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [CFG_W-1:0] RESET_BASE_TIMEOUT = 16'd500;
	localparam logic [CFG_W-1:0] RESET_US_PER_BYTE = 16'd12;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_BYTE = 1'd1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_TICK = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_CHECKSUM = 3'd1,
		ST_ID_MISMATCH = 3'd2,
		ST_OVERRUN = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic [7:0] expected_id;
	} req_t;

	typedef struct packed {
		logic kind;
		logic [7:0] payload_byte;
		logic [2:0] status_code;
	} rsp_t;

endpackage

// File: rtl/core/sbsr_req_if.sv
// Request channel: command, received byte and expected ID.
interface sbsr_req_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [7:0] rx_byte;
	logic [7:0] expected_id;

	modport source (output valid, output command, output rx_byte, output expected_id,
		input ready);
	modport sink (input valid, input command, input rx_byte, input expected_id,
		output ready);
endinterface

// File: rtl/core/sbsr_rsp_if.sv
// Result channel: payload bytes and the final status of a packet.
interface sbsr_rsp_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [7:0] payload_byte;
	logic [2:0] status_code;

	modport source (output valid, output result_kind, output payload_byte,
		output status_code, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input status_code, output ready);
endinterface

// File: rtl/core/sbsr_cfg_if.sv
// Configuration write channel: register index and write data.
interface sbsr_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/servo_bus_status_packet_receiver.sv
// Top level of the servo-bus status packet receiver.
// Channels: req (sink) takes one request a cycle while rsp drains: command START
// with expected_id, BYTE with rx_byte, or TICK for one elapsed microsecond.
// rsp (source) gives payload bytes (error and parameter bytes of the reply) and
// one final status per packet. cfg writes base_timeout_us (index 0) and us_per_byte
// (index 1) and is always ready; write it only while no packet is in flight.
// Order: a request is first held in the input register, and its result is then
// loaded into the result register, which drives rsp.
// Throughput: one request per cycle while rsp keeps draining; the parser step
// is a single combinational pass from the input register to the result
// register, with one 8x16 multiply for the length-based deadline.
// Stall: when rsp holds ready low with a result waiting, the input register
// keeps its request and req.ready drops once that register is full.
// Reset: arst_n clears both registers' valid flags and the receive state, and
// loads the timeout registers with 500 us base and 12 us per byte.
module servo_bus_status_packet_receiver import sbsr_pkg::*; #(
	parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	sbsr_req_if.sink   req,
	sbsr_rsp_if.source rsp,
	sbsr_cfg_if.sink   cfg
);

	logic             valid_s1;
	req_t             item_s1;
	logic             advance;
	logic             out_free;
	logic             res_valid;
	rsp_t             res;
	logic [CFG_W-1:0] base_timeout_q;
	logic [CFG_W-1:0] us_per_byte_q;

	assign advance = valid_s1 && out_free;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			item_s1 <= '{command: req.command, rx_byte: req.rx_byte,
				expected_id: req.expected_id};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_timeout_q <= RESET_BASE_TIMEOUT;
			us_per_byte_q <= RESET_US_PER_BYTE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BASE_TIMEOUT: base_timeout_q <= cfg.data;
				REG_US_PER_BYTE:  us_per_byte_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	sbsr_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.base_timeout_us(base_timeout_q),
		.us_per_byte(us_per_byte_q),
		.res_valid(res_valid),
		.res(res)
	);

	sbsr_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && res_valid),
		.res(res),
		.free(out_free),
		.rsp(rsp)
	);

endmodule

// File: rtl/core/sbsr_parser.sv
// Packet parser: receive state, checksum, timer and at most one result per request.
`include "servo_bus_status_packet_receiver_macros.svh"

module sbsr_parser import sbsr_pkg::*; #(
	parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  req_t             item,
	input  logic [CFG_W-1:0] base_timeout_us,
	input  logic [CFG_W-1:0] us_per_byte,
	output logic             res_valid,
	output rsp_t             res
);

	localparam logic [POS_W-1:0] BUF_LIMIT = POS_W'(BUFFER_BYTES);
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	logic              receiving_q, receiving_d;
	logic              timer_running_q, timer_running_d;
	logic [POS_W-1:0]  byte_position_q, byte_position_d;
	logic [7:0]        wanted_id_q, wanted_id_d;
	logic [7:0]        reply_id_q, reply_id_d;
	logic [7:0]        announced_length_q, announced_length_d;
	logic              length_known_q, length_known_d;
	logic [7:0]        running_sum_q, running_sum_d;
	logic [TIME_W-1:0] elapsed_us_q, elapsed_us_d;
	logic [TIME_W-1:0] deadline_us_q, deadline_us_d;

	logic [TIME_W-1:0] deadline_base;
	logic [23:0]       length_time;
	logic [POS_W-1:0]  count;
	logic [TIME_W-1:0] elapsed_inc;
	logic [7:0]        b;

	assign b = item.rx_byte;
	assign deadline_base = timer_running_q ? deadline_us_q : TIME_W'(base_timeout_us);
	assign length_time = {16'd0, b} * {8'd0, us_per_byte};
	assign count = byte_position_q + POS_W'(1);
	assign elapsed_inc = (elapsed_us_q == TIME_MAX) ? elapsed_us_q
		: elapsed_us_q + TIME_W'(1);

	always_comb begin
		receiving_d = receiving_q;
		timer_running_d = timer_running_q;
		byte_position_d = byte_position_q;
		wanted_id_d = wanted_id_q;
		reply_id_d = reply_id_q;
		announced_length_d = announced_length_q;
		length_known_d = length_known_q;
		running_sum_d = running_sum_q;
		elapsed_us_d = elapsed_us_q;
		deadline_us_d = deadline_us_q;
		res_valid = 1'b0;
		res = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, status_code: ST_OK};

		unique case (cmd_t'(item.command))
			CMD_START: begin
				receiving_d = 1'b1;
				timer_running_d = 1'b0;
				byte_position_d = '0;
				wanted_id_d = item.expected_id;
				reply_id_d = '0;
				announced_length_d = '0;
				length_known_d = 1'b0;
				running_sum_d = '0;
				elapsed_us_d = '0;
				deadline_us_d = '0;
			end
			CMD_BYTE: begin
				if (receiving_q) begin
					if (!timer_running_q) begin
						timer_running_d = 1'b1;
						elapsed_us_d = '0;
						deadline_us_d = deadline_base;
					end
					if (byte_position_q == POS_W'(0)) begin
						// drop anything but the first header byte
						if (b == HEADER_BYTE)
							byte_position_d = POS_W'(1);
					end else if (byte_position_q == POS_W'(1)) begin
						byte_position_d = (b == HEADER_BYTE) ? POS_W'(2) : POS_W'(0);
					end else begin
						byte_position_d = count;
						if (byte_position_q == POS_W'(2)) begin
							reply_id_d = b;
							running_sum_d = b;
						end else if (byte_position_q == POS_W'(3)) begin
							announced_length_d = b;
							length_known_d = 1'b1;
							running_sum_d = running_sum_q + b;
							deadline_us_d = deadline_base + TIME_W'(length_time);
							// zero length leaves no room for a checksum byte
							if (b == 8'd0) begin
								res_valid = 1'b1;
								res.kind = KIND_STATUS;
								res.status_code = ST_CHECKSUM;
							end
						end else if (length_known_q
							&& count == POS_W'(4) + POS_W'(announced_length_q)) begin
							res_valid = 1'b1;
							res.kind = KIND_STATUS;
							if (b != ~running_sum_q)
								res.status_code = ST_CHECKSUM;
							else if (reply_id_q != wanted_id_q)
								res.status_code = ST_ID_MISMATCH;
							else
								res.status_code = ST_OK;
						end else begin
							running_sum_d = running_sum_q + b;
							res_valid = 1'b1;
							if (count == BUF_LIMIT) begin
								res.kind = KIND_STATUS;
								res.status_code = ST_OVERRUN;
							end else begin
								res.payload_byte = b;
							end
						end
					end
				end
			end
			CMD_TICK: begin
				if (receiving_q && timer_running_q) begin
					elapsed_us_d = elapsed_inc;
					if (elapsed_inc >= deadline_us_q) begin
						res_valid = 1'b1;
						res.kind = KIND_STATUS;
						res.status_code = ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase

		// any status ends the receive
		if (res_valid && res.kind == KIND_STATUS) begin
			receiving_d = 1'b0;
			timer_running_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			timer_running_q <= 1'b0;
			byte_position_q <= '0;
			wanted_id_q <= '0;
			reply_id_q <= '0;
			announced_length_q <= '0;
			length_known_q <= 1'b0;
			running_sum_q <= '0;
			elapsed_us_q <= '0;
			deadline_us_q <= '0;
		end else if (step) begin
			receiving_q <= receiving_d;
			timer_running_q <= timer_running_d;
			byte_position_q <= byte_position_d;
			wanted_id_q <= wanted_id_d;
			reply_id_q <= reply_id_d;
			announced_length_q <= announced_length_d;
			length_known_q <= length_known_d;
			running_sum_q <= running_sum_d;
			elapsed_us_q <= elapsed_us_d;
			deadline_us_q <= deadline_us_d;
		end
	end

	`SBSR_ASSERT_NEXT(a_status_ends_receive, clk, arst_n,
		step && res_valid && res.kind == KIND_STATUS, !receiving_q && !timer_running_q,
		"status result did not end the receive")
	`SBSR_ASSERT_NOW(a_timer_needs_receive, clk, arst_n,
		timer_running_q, receiving_q, "timer running outside a receive")
	`SBSR_ASSERT_NOW(a_position_in_buffer, clk, arst_n,
		receiving_q, byte_position_q <= BUF_LIMIT, "byte position past buffer size")
	`SBSR_ASSERT_NOW(a_fields_exclusive, clk, arst_n,
		res_valid, (res.kind == KIND_PAYLOAD) ? (res.status_code == ST_OK)
		: (res.payload_byte == 8'd0), "payload and status fields both set")

endmodule

// File: rtl/core/sbsr_out_reg.sv
// Result register in front of the result channel.
module sbsr_out_reg import sbsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rsp_t        res,
	output logic        free,
	sbsr_rsp_if.source  rsp
);

	logic valid_q;
	rsp_t data_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= res;
	end

	assign rsp.valid = valid_q;
	assign rsp.result_kind = data_q.kind;
	assign rsp.payload_byte = data_q.payload_byte;
	assign rsp.status_code = data_q.status_code;

endmodule
